// ----- sv/assert_macros.svh -----
// assertion macros shared by the tokenizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define STT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define STT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/stt_pkg.sv -----
// shared types, constants and helpers of the source text tokenizer
package stt_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LINE_BITS_DEF     = 16;

    // wide enough for a counter of up to 32 bits plus one carry bit
    localparam int SAT_IN_BITS = 33;

    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = 64;

    typedef enum logic [3:0] {
        KIND_INVALID    = 4'd0,
        KIND_VARIABLE   = 4'd1,
        KIND_IDENTIFIER = 4'd2,
        KIND_ASSIGN     = 4'd3,
        KIND_STRING     = 4'd4,
        KIND_NUMBER     = 4'd5,
        KIND_OPERATOR   = 4'd6,
        KIND_LPAREN     = 4'd7,
        KIND_RPAREN     = 4'd8,
        KIND_COMMA      = 4'd9,
        KIND_BOOLEAN    = 4'd10
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] line_number;
        logic [15:0] start_offset;
        logic [15:0] span_length;
        logic [7:0]  symbol;
    } token_t;

    typedef struct packed {
        logic   first_valid;
        logic   second_valid;
        token_t first;
        token_t second;
    } result_pair_t;

    // character codes
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // keyword table: variable keyword, true boolean, false boolean
    localparam int KW_COUNT = 3;
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{8'h64, 8'h69, 8'h63, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h62, 8'h6F, 8'h6F, 8'h62, 8'h73, 8'h00, 8'h00, 8'h00},
        '{8'h6E, 8'h6F, 8'h5F, 8'h62, 8'h6F, 8'h6F, 8'h62, 8'h73}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd5, 4'd8};

    function automatic logic [15:0] sat16(input logic [SAT_IN_BITS-1:0] v);
        logic [15:0] r;
        if (v > SAT_IN_BITS'(17'h0FFFF)) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/stt_scan.sv -----
// tokenizer state and per-byte decode, up to two tokens per byte
`include "assert_macros.svh"

module stt_scan
    import stt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   ch,
    input  logic         end_of_source,
    output result_pair_t results
);

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_WORD    = 4'b0010,
        MODE_STRING  = 4'b0100,
        MODE_COMMENT = 4'b1000
    } mode_t;

    typedef enum logic [4:0] {
        FORM_START = 5'b00001,
        FORM_INT   = 5'b00010,
        FORM_DOT   = 5'b00100,
        FORM_FRAC  = 5'b01000,
        FORM_DEAD  = 5'b10000
    } form_t;

    typedef struct packed {
        logic [KW_COUNT-1:0] flags;
        form_t               form;
        logic [3:0]          len;
    } word_t;

    localparam word_t WORD_FRESH = '{flags: '1, form: FORM_START, len: 4'd0};
    localparam word_t WORD_RESET = '{flags: '0, form: FORM_START, len: 4'd0};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic word_t word_add(input word_t w, input logic [7:0] c);
        word_t r;
        r = w;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (!((w.len < KW_LEN[k]) && (KW_TEXT[k][w.len[2:0]] == c))) begin
                r.flags[k] = 1'b0;
            end
        end
        unique case (w.form)
            FORM_START: r.form = is_digit(c) ? FORM_INT : FORM_DEAD;
            FORM_INT:   r.form = is_digit(c) ? FORM_INT :
                                 ((c == CH_DOT) ? FORM_DOT : FORM_DEAD);
            FORM_DOT:   r.form = is_digit(c) ? FORM_FRAC : FORM_DEAD;
            FORM_FRAC:  r.form = is_digit(c) ? FORM_FRAC : FORM_DEAD;
            default:    r.form = FORM_DEAD;
        endcase
        if (w.len != 4'd15) begin
            r.len = w.len + 4'd1;
        end
        return r;
    endfunction

    mode_t                    mode_reg, mode_next;
    logic                     quote_dq_reg, quote_dq_next;
    logic                     escape_reg, escape_next;
    word_t                    word_reg, word_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic [POSITION_BITS-1:0] pos_bumped;
    logic [LINE_BITS-1:0]     line_bumped;
    logic [POSITION_BITS:0]   span_base;
    logic [POSITION_BITS:0]   span_incl;
    logic [15:0]              line_out;
    logic [15:0]              pos_out;
    logic [15:0]              start_out;
    kind_t                    word_kind;
    logic [7:0]               quote_ch;

    // single-byte decode in normal mode
    logic  nb_emit, nb_string, nb_word, nb_comment, nb_newline;
    kind_t nb_kind;

    token_t word_tok, nb_tok, str_tok;
    logic   run_normal, word_emit, str_emit, bump;
    kind_t  str_kind;
    logic [15:0] str_span;

    assign pos_bumped  = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign line_bumped = (line_reg == '1) ? line_reg : line_reg + 1'b1;
    assign span_base   = {1'b0, pos_reg} - {1'b0, start_reg};
    assign span_incl   = span_base + 1'b1;
    assign line_out    = sat16(SAT_IN_BITS'(line_reg));
    assign pos_out     = sat16(SAT_IN_BITS'(pos_reg));
    assign start_out   = sat16(SAT_IN_BITS'(start_reg));
    assign quote_ch    = quote_dq_reg ? CH_DQUOTE : CH_SQUOTE;

    always_comb begin
        priority if (word_reg.flags[0] && (word_reg.len == 4'd4)) begin
            word_kind = KIND_VARIABLE;
        end else if ((word_reg.form == FORM_INT) || (word_reg.form == FORM_FRAC)) begin
            word_kind = KIND_NUMBER;
        end else if ((word_reg.flags[1] && (word_reg.len == 4'd5)) ||
                     (word_reg.flags[2] && (word_reg.len == 4'd8))) begin
            word_kind = KIND_BOOLEAN;
        end else begin
            word_kind = KIND_IDENTIFIER;
        end
    end

    always_comb begin
        nb_emit    = 1'b0;
        nb_kind    = KIND_INVALID;
        nb_string  = 1'b0;
        nb_word    = 1'b0;
        nb_comment = 1'b0;
        nb_newline = 1'b0;
        priority if (ch == CH_EQUALS) begin
            nb_emit = 1'b1;
            nb_kind = KIND_ASSIGN;
        end else if ((ch == CH_SQUOTE) || (ch == CH_DQUOTE)) begin
            nb_string = 1'b1;
        end else if (ch == CH_LPAREN) begin
            nb_emit = 1'b1;
            nb_kind = KIND_LPAREN;
        end else if (ch == CH_RPAREN) begin
            nb_emit = 1'b1;
            nb_kind = KIND_RPAREN;
        end else if (ch == CH_COMMA) begin
            nb_emit = 1'b1;
            nb_kind = KIND_COMMA;
        end else if (is_alnum(ch)) begin
            nb_word = 1'b1;
        end else if (ch == CH_HASH) begin
            nb_comment = 1'b1;
        end else if ((ch == CH_PLUS) || (ch == CH_MINUS) ||
                     (ch == CH_SLASH) || (ch == CH_STAR)) begin
            nb_emit = 1'b1;
            nb_kind = KIND_OPERATOR;
        end else if (ch == CH_NEWLINE) begin
            nb_newline = 1'b1;
        end else if (ch == CH_SPACE) begin
            nb_emit = 1'b0;
        end else begin
            nb_emit = 1'b1;
            nb_kind = KIND_INVALID;
        end
    end

    always_comb begin
        word_tok = '{kind: word_kind, line_number: line_out, start_offset: start_out,
                     span_length: sat16(SAT_IN_BITS'(span_base)), symbol: 8'h00};
        nb_tok   = '{kind: nb_kind, line_number: line_out, start_offset: pos_out,
                     span_length: 16'd1, symbol: ch};
        str_tok  = '{kind: str_kind, line_number: line_out, start_offset: start_out,
                     span_length: str_span, symbol: 8'h00};
    end

    always_comb begin
        mode_next     = mode_reg;
        quote_dq_next = quote_dq_reg;
        escape_next   = escape_reg;
        word_next     = word_reg;
        start_next    = start_reg;
        line_next     = line_reg;
        pos_next      = pos_reg;
        run_normal    = 1'b0;
        word_emit     = 1'b0;
        str_emit      = 1'b0;
        str_kind      = KIND_INVALID;
        str_span      = sat16(SAT_IN_BITS'(span_incl));
        bump          = 1'b0;
        results       = '0;

        if (step && end_of_source) begin
            // flush, then back to the reset values
            if (mode_reg == MODE_WORD) begin
                word_emit = 1'b1;
            end else if (mode_reg == MODE_STRING) begin
                str_emit = 1'b1;
                str_span = sat16(SAT_IN_BITS'(span_base));
            end
            mode_next     = MODE_NORMAL;
            quote_dq_next = 1'b0;
            escape_next   = 1'b0;
            word_next     = WORD_RESET;
            start_next    = '0;
            line_next     = LINE_BITS'(1);
            pos_next      = '0;
        end else if (step) begin
            unique case (mode_reg)
                MODE_WORD: begin
                    if (is_alnum(ch) || (ch == CH_DOT) || (ch == CH_UNDERSCORE)) begin
                        word_next = word_add(word_reg, ch);
                        bump      = 1'b1;
                    end else begin
                        // terminator is not part of the word, rescan it
                        word_emit  = 1'b1;
                        run_normal = 1'b1;
                    end
                end
                MODE_STRING: begin
                    bump = 1'b1;
                    if (escape_reg) begin
                        escape_next = 1'b0;
                    end else if ((ch == quote_ch) || (ch == CH_NEWLINE) || (ch == CH_NUL)) begin
                        str_emit  = 1'b1;
                        str_kind  = (ch == quote_ch) ? KIND_STRING : KIND_INVALID;
                        mode_next = MODE_NORMAL;
                    end else if (ch == CH_BACKSLASH) begin
                        escape_next = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if ((ch == CH_NEWLINE) || (ch == CH_NUL)) begin
                        run_normal = 1'b1;
                    end else begin
                        bump = 1'b1;
                    end
                end
                default: begin
                    run_normal = 1'b1;
                end
            endcase

            if (run_normal) begin
                mode_next = MODE_NORMAL;
                bump      = 1'b1;
                if (nb_newline) begin
                    line_next = line_bumped;
                end
                if (nb_string) begin
                    mode_next     = MODE_STRING;
                    quote_dq_next = (ch == CH_DQUOTE);
                    escape_next   = 1'b0;
                    start_next    = pos_reg;
                end
                if (nb_word) begin
                    mode_next  = MODE_WORD;
                    start_next = pos_reg;
                    word_next  = word_add(WORD_FRESH, ch);
                end
                if (nb_comment) begin
                    mode_next = MODE_COMMENT;
                end
            end
            if (bump) begin
                pos_next = pos_bumped;
            end
        end

        priority if (word_emit) begin
            results.first_valid  = 1'b1;
            results.first        = word_tok;
            results.second_valid = run_normal && nb_emit;
            results.second       = nb_tok;
        end else if (str_emit) begin
            results.first_valid = 1'b1;
            results.first       = str_tok;
        end else if (run_normal && nb_emit) begin
            results.first_valid = 1'b1;
            results.first       = nb_tok;
        end else begin
            results.first_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_NORMAL;
            quote_dq_reg <= 1'b0;
            escape_reg   <= 1'b0;
            word_reg     <= WORD_RESET;
            start_reg    <= '0;
            line_reg     <= LINE_BITS'(1);
            pos_reg      <= '0;
        end else begin
            mode_reg     <= mode_next;
            quote_dq_reg <= quote_dq_next;
            escape_reg   <= escape_next;
            word_reg     <= word_next;
            start_reg    <= start_next;
            line_reg     <= line_next;
            pos_reg      <= pos_next;
        end
    end

    `STT_ASSERT(a_escape_only_in_string, aclk, aresetn,
        escape_reg |-> (mode_reg == MODE_STRING), "escape pending outside a string")
    `STT_ASSERT(a_line_nonzero, aclk, aresetn,
        line_reg != '0, "line count dropped to zero")
    `STT_ASSERT_NEXT(a_end_restarts, aclk, aresetn, step && end_of_source,
        (mode_reg == MODE_NORMAL) && (pos_reg == '0), "end marker did not restart the scan")

endmodule

// ----- sv/stt_out_queue.sv -----
// three-entry token queue in front of the result channel
`include "assert_macros.svh"

module stt_out_queue
    import stt_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  result_pair_t            push_pair,
    output logic                    has_room,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,  // kind, line_number, start_offset, span_length, symbol
    output logic                    m_tlast
);

    typedef struct packed {
        token_t tok;
        logic   last;
    } entry_t;

    localparam int DEPTH = 3;

    entry_t     q_reg [DEPTH];
    entry_t     q_next [DEPTH];
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] base;
    logic [1:0] push_n;

    assign has_room = (count_reg <= 2'd1);
    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign base     = count_reg - {1'b0, pop};
    assign push_n   = {1'b0, push_pair.first_valid} + {1'b0, push_pair.second_valid};

    assign m_tdata = {4'b0000, q_reg[0].tok.symbol, q_reg[0].tok.span_length,
                      q_reg[0].tok.start_offset, q_reg[0].tok.line_number,
                      q_reg[0].tok.kind};
    assign m_tlast = q_reg[0].last;

    always_comb begin
        q_next = q_reg;
        if (pop) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        // last marks the final token of the request
        if (push_pair.first_valid) begin
            q_next[base] = '{tok: push_pair.first, last: !push_pair.second_valid};
        end
        if (push_pair.second_valid) begin
            q_next[base + 2'd1] = '{tok: push_pair.second, last: 1'b1};
        end
        count_next = base + push_n;
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    `STT_ASSERT(a_push_needs_room, aclk, aresetn,
        push_pair.first_valid |-> (count_reg <= 2'd1), "token pushed into a full queue")
    `STT_ASSERT(a_second_after_first, aclk, aresetn,
        push_pair.second_valid |-> push_pair.first_valid, "second token without a first")

endmodule

// ----- sv/source_text_tokenizer.sv -----
// top level of the source text tokenizer
// Source bytes arrive on the s_ channel, one byte per request: s_tdata holds the
// byte, s_tlast marks the end of the source (the byte is then ignored and any
// open word or string is flushed, after which line and position start over).
// Tokens leave on the m_ channel, one per request; m_tlast is set on the last
// token that a given input request produced. A request may produce no token,
// one token, or two (a word followed by the single-character token that ends it).
// An accepted byte is held in the input register until the queue has room,
// then decoded into the output queue, from which its tokens are offered.
// Throughput: one byte per cycle while each byte yields at most one token and
// m_tready is high; after a byte yielding two tokens the next byte waits for
// the one-token-per-cycle drain of the three-entry output queue.
// When m_tready is low the queue holds up to three tokens and the input
// register holds one more byte; s_tready falls once that register is full and no
// room is left for the two tokens a byte may need.
// Reset (aresetn low, synchronous) empties the queue and the input register and
// returns the scanner to normal mode on line one, byte zero.
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,  // ch
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,  // kind, line_number, start_offset, span_length, symbol
    output logic                    m_tlast
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_ch_reg;
    logic         in_end_reg;
    logic         has_room;
    logic         step;
    logic         load;
    result_pair_t results;

    assign step     = in_valid_reg && has_room;
    assign s_tready = !in_valid_reg || has_room;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            in_ch_reg  <= s_tdata[7:0];
            in_end_reg <= s_tlast;
        end
    end

    stt_scan #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .ch            (in_ch_reg),
        .end_of_source (in_end_reg),
        .results       (results)
    );

    stt_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_pair (results),
        .has_room  (has_room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
